@@ rtl/core/ebq_pkg.sv @@
package ebq_pkg;

    // Register field widths
    localparam int DEBOUNCE_W = 10;
    localparam int LONG_W     = 16;
    localparam int ACCEL_W    = 8;
    localparam int STEP_MAG_W = 7;
    localparam int STEP_W     = 8;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam int S_DATA_W   = 8;
    localparam int M_DATA_W   = 16;

    // Register indexes on the write port
    localparam logic [CFG_ADDR_W-1:0] CFG_DEBOUNCE  = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_LONG      = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_ACCEL     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_SLOW_STEP = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_FAST_STEP = 3'd4;

    // Reset values of the registers
    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST  = 10'd100;
    localparam logic [LONG_W-1:0]     LONG_RST      = 16'd3000;
    localparam logic [ACCEL_W-1:0]    ACCEL_RST     = 8'd20;
    localparam logic [STEP_MAG_W-1:0] SLOW_STEP_RST = 7'd1;
    localparam logic [STEP_MAG_W-1:0] FAST_STEP_RST = 7'd10;

    typedef enum logic [2:0] {
        PH_UP        = 3'd0,
        PH_UP_DEB    = 3'd1,
        PH_DOWN      = 3'd2,
        PH_LONG_DOWN = 3'd3,
        PH_DOWN_DEB  = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_PRESS = 2'd1,
        EV_LONG  = 2'd2
    } event_t;

    // One poll word, bit 7 first
    typedef struct packed {
        logic clear_events;
        logic take_long_press;
        logic take_press;
        logic take_step;
        logic code_level;
        logic edge_seen;
        logic button_pressed;
        logic tick_ms;
    } poll_t;

    // Side effects of the button machine for one poll
    typedef struct packed {
        logic load_debounce;
        logic load_long;
        logic set_press;
        logic set_long;
    } btn_act_t;

endpackage

@@ rtl/core/encoder_button_qualifier.sv @@
// Channel   Dir  Ports                         Word
// s_ poll   in   s_tvalid s_tready s_tdata     one poll: tick, button, edge, requests
// m_ result out  m_tvalid m_tready m_tdata     step, press/long found, pending event
// cfg       in   cfg_wr_en cfg_addr cfg_wdata  register write, no read-back
//
// Flow: one poll word per clock while m_tready stays high; an accepted word passes
// the input register, update logic and result register on its way to m_.
// Reset: synchronous aresetn low; registers return to 100/3000/20/1/10 ms/steps,
// button up, timers expired, no event, step zero.
// Stalls: m_tready low holds the result; one more poll word parks in the
// input register before s_tready drops.
module encoder_button_qualifier
    import ebq_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // [0] tick_ms [1] button_pressed [2] edge_seen [3] code_level
    // [4] take_step [5] take_press [6] take_long_press [7] clear_events
    input  logic [S_DATA_W-1:0]   s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [7:0] step_value (signed) [8] press_found [9] long_press_found
    // [11:10] event_pending [15:12] zero
    output logic [M_DATA_W-1:0]   m_tdata,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    // Configuration registers
    logic [DEBOUNCE_W-1:0] debounce_ms_reg;
    logic [LONG_W-1:0]     long_press_ms_reg;
    logic [ACCEL_W-1:0]    accel_window_reg;
    logic [STEP_MAG_W-1:0] slow_step_reg;
    logic [STEP_MAG_W-1:0] fast_step_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_ms_reg   <= DEBOUNCE_RST;
            long_press_ms_reg <= LONG_RST;
            accel_window_reg  <= ACCEL_RST;
            slow_step_reg     <= SLOW_STEP_RST;
            fast_step_reg     <= FAST_STEP_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_DEBOUNCE:  debounce_ms_reg   <= cfg_wdata[DEBOUNCE_W-1:0];
                CFG_LONG:      long_press_ms_reg <= cfg_wdata[LONG_W-1:0];
                CFG_ACCEL:     accel_window_reg  <= cfg_wdata[ACCEL_W-1:0];
                CFG_SLOW_STEP: slow_step_reg     <= cfg_wdata[STEP_MAG_W-1:0];
                CFG_FAST_STEP: fast_step_reg     <= cfg_wdata[STEP_MAG_W-1:0];
                default: ;
            endcase
        end
    end

    // Input register and handshake
    logic  in_valid_reg;
    poll_t in_word_reg;
    logic  m_valid_reg;
    logic  advance;

    // the parked word moves on whenever the result slot is free or being taken
    assign advance  = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_word_reg <= poll_t'(s_tdata);
        end
    end

    // Qualifier state
    phase_t                phase_reg, phase_next;
    logic [DEBOUNCE_W-1:0] debounce_left_reg, debounce_left_next;
    logic [LONG_W-1:0]     long_left_reg, long_left_next;
    logic [ACCEL_W-1:0]    accel_left_reg, accel_left_next;
    event_t                event_reg, event_next;
    logic [STEP_W-1:0]     step_reg, step_next;

    // timers after this poll's tick
    logic [DEBOUNCE_W-1:0] deb_dec;
    logic [LONG_W-1:0]     long_dec;
    logic [ACCEL_W-1:0]    accel_dec;
    logic                  deb_done;
    logic                  long_done;
    logic                  down;
    btn_act_t              act;

    assign deb_dec   = (in_word_reg.tick_ms && debounce_left_reg != '0)
                       ? debounce_left_reg - 1'b1 : debounce_left_reg;
    assign long_dec  = (in_word_reg.tick_ms && long_left_reg != '0)
                       ? long_left_reg - 1'b1 : long_left_reg;
    assign accel_dec = (in_word_reg.tick_ms && accel_left_reg != '0)
                       ? accel_left_reg - 1'b1 : accel_left_reg;
    assign deb_done  = (deb_dec == '0);
    assign long_done = (long_dec == '0);
    assign down      = in_word_reg.button_pressed;

    // Button machine: next phase
    always_comb begin
        phase_next = phase_reg;
        case (phase_reg)
            PH_UP_DEB: begin
                if (deb_done) begin
                    phase_next = down ? PH_DOWN : PH_UP;
                end
            end
            PH_DOWN: begin
                if (!down) begin
                    phase_next = PH_DOWN_DEB;
                end else if (long_done) begin
                    phase_next = PH_LONG_DOWN;
                end
            end
            PH_LONG_DOWN: begin
                if (!down) begin
                    phase_next = PH_DOWN_DEB;
                end
            end
            PH_DOWN_DEB: begin
                if (deb_done) begin
                    if (!down) begin
                        phase_next = PH_UP;
                    end else begin
                        phase_next = long_done ? PH_LONG_DOWN : PH_DOWN;
                    end
                end
            end
            default: begin
                phase_next = down ? PH_UP_DEB : PH_UP;
            end
        endcase
    end

    // Button machine: timer loads and events
    always_comb begin
        act = '0;
        case (phase_reg)
            PH_UP_DEB: begin
                act.load_long = deb_done && down;
            end
            PH_DOWN: begin
                act.load_debounce = !down;
                act.set_long      = down && long_done;
            end
            PH_LONG_DOWN: begin
                act.load_debounce = !down;
            end
            PH_DOWN_DEB: begin
                // release confirmed before the hold time ran out
                act.set_press = deb_done && !down && !long_done;
            end
            default: begin
                act.load_debounce = down;
            end
        endcase
    end

    // Encoder, requests and clear
    logic [STEP_MAG_W-1:0] mag;
    logic [STEP_W-1:0]     edge_step;
    logic [STEP_W-1:0]     step_mid;
    event_t                event_mid;
    event_t                event_after_press;
    logic                  press_found;
    logic                  long_found;
    logic [STEP_W-1:0]     step_out;

    assign mag       = (accel_dec == '0) ? slow_step_reg : fast_step_reg;
    assign edge_step = in_word_reg.code_level ? STEP_W'(-{1'b0, mag}) : {1'b0, mag};
    assign step_mid  = in_word_reg.edge_seen ? edge_step : step_reg;
    assign event_mid = act.set_long ? EV_LONG : (act.set_press ? EV_PRESS : event_reg);

    assign press_found       = in_word_reg.take_press && (event_mid == EV_PRESS);
    assign event_after_press = press_found ? EV_NONE : event_mid;
    assign long_found        = in_word_reg.take_long_press && (event_after_press == EV_LONG);
    assign step_out          = in_word_reg.take_step ? step_mid : '0;

    always_comb begin
        debounce_left_next = act.load_debounce ? debounce_ms_reg : deb_dec;
        long_left_next     = act.load_long ? long_press_ms_reg : long_dec;
        accel_left_next    = in_word_reg.edge_seen ? accel_window_reg : accel_dec;
        if (in_word_reg.clear_events || long_found) begin
            event_next = EV_NONE;
        end else begin
            event_next = event_after_press;
        end
        if (in_word_reg.clear_events || in_word_reg.take_step) begin
            step_next = '0;
        end else begin
            step_next = step_mid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_UP;
            debounce_left_reg <= '0;
            long_left_reg     <= '0;
            accel_left_reg    <= '0;
            event_reg         <= EV_NONE;
            step_reg          <= '0;
        end else if (advance) begin
            phase_reg         <= phase_next;
            debounce_left_reg <= debounce_left_next;
            long_left_reg     <= long_left_next;
            accel_left_reg    <= accel_left_next;
            event_reg         <= event_next;
            step_reg          <= step_next;
        end
    end

    // Result register
    logic [M_DATA_W-1:0] m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg <= {4'b0000, event_next, long_found, press_found, step_out};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

`ifndef NO_ASSERTIONS
    a_long_down_expired: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_LONG_DOWN |-> long_left_reg == '0)
        else $error("long-down phase with hold timer still running");

    a_no_bad_event: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[11:10] != 2'd3)
        else $error("undefined pending event code on result");

    a_press_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[8] |-> m_tdata[11:10] == EV_NONE && !m_tdata[9])
        else $error("press found but event still reported");

    a_advance_fills: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_tvalid)
        else $error("processed word did not reach result register");

    a_accept_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_tready)
        else $error("input register empty but poll not accepted");
`endif

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
    import ebq_pkg::*;

    // Write port index with no register behind it; a write there must change nothing
    localparam logic [CFG_ADDR_W-1:0] CFG_NONE = 3'd7;

    // Poll word flags, same bit order as poll_t
    localparam logic [S_DATA_W-1:0] P_TICK   = 8'h01;
    localparam logic [S_DATA_W-1:0] P_DOWN   = 8'h02;
    localparam logic [S_DATA_W-1:0] P_EDGE   = 8'h04;
    localparam logic [S_DATA_W-1:0] P_NEG    = 8'h08;
    localparam logic [S_DATA_W-1:0] P_TSTEP  = 8'h10;
    localparam logic [S_DATA_W-1:0] P_TPRESS = 8'h20;
    localparam logic [S_DATA_W-1:0] P_TLONG  = 8'h40;
    localparam logic [S_DATA_W-1:0] P_CLEAR  = 8'h80;

    // Result word as it leaves m_tdata, lowest field last
    typedef struct packed {
        logic [3:0]        unused;
        event_t            pending;
        logic              long_found;
        logic              press_found;
        logic signed [7:0] step;
    } result_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // [0] tick_ms [1] button_pressed [2] edge_seen [3] code_level
    // [4] take_step [5] take_press [6] take_long_press [7] clear_events
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // [7:0] step_value (signed) [8] press_found [9] long_found [11:10] event_pending
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    encoder_button_qualifier dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor: own copy of the registers and the qualifier state
    // ------------------------------------------------------------------
    logic [DEBOUNCE_W-1:0] deb_ms     = DEBOUNCE_RST;
    logic [LONG_W-1:0]     long_ms    = LONG_RST;
    logic [ACCEL_W-1:0]    accel_ms   = ACCEL_RST;
    logic [STEP_MAG_W-1:0] slow_mag   = SLOW_STEP_RST;
    logic [STEP_MAG_W-1:0] fast_mag   = FAST_STEP_RST;

    phase_t                btn_phase  = PH_UP;
    logic [DEBOUNCE_W-1:0] deb_left   = '0;
    logic [LONG_W-1:0]     long_left  = '0;
    logic [ACCEL_W-1:0]    accel_left = '0;
    event_t                pend_ev    = EV_NONE;
    logic [STEP_W-1:0]     held_step  = '0;

    result_t result_q[$];   // expected result words, oldest first

    // Run one poll through the qualifier state and return its result word
    function automatic result_t qualify_poll(input poll_t p);
        result_t               r;
        logic [STEP_MAG_W-1:0] mag;
        r = '0;

        // timers first, saturating at zero (zero = expired)
        if (p.tick_ms) begin
            if (deb_left != 0) deb_left = deb_left - 1'b1;
            if (long_left != 0) long_left = long_left - 1'b1;
            if (accel_left != 0) accel_left = accel_left - 1'b1;
        end

        case (btn_phase)
            PH_UP_DEB: begin
                if (deb_left == 0) begin
                    if (p.button_pressed) begin
                        btn_phase = PH_DOWN;
                        long_left = long_ms;
                    end else begin
                        btn_phase = PH_UP;
                    end
                end
            end
            PH_DOWN: begin
                if (!p.button_pressed) begin
                    btn_phase = PH_DOWN_DEB;
                    deb_left  = deb_ms;
                end else if (long_left == 0) begin
                    btn_phase = PH_LONG_DOWN;
                    pend_ev   = EV_LONG;
                end
            end
            PH_LONG_DOWN: begin
                if (!p.button_pressed) begin
                    btn_phase = PH_DOWN_DEB;
                    deb_left  = deb_ms;
                end
            end
            PH_DOWN_DEB: begin
                if (deb_left == 0) begin
                    if (!p.button_pressed) begin
                        // release before the long-press time ran out: short press
                        if (long_left != 0) pend_ev = EV_PRESS;
                        btn_phase = PH_UP;
                    end else begin
                        btn_phase = (long_left != 0) ? PH_DOWN : PH_LONG_DOWN;
                    end
                end
            end
            default: begin
                btn_phase = PH_UP;
                if (p.button_pressed) begin
                    btn_phase = PH_UP_DEB;
                    deb_left  = deb_ms;
                end
            end
        endcase

        // edge overwrites the step; fast magnitude while the window is open
        if (p.edge_seen) begin
            mag        = (accel_left == 0) ? slow_mag : fast_mag;
            held_step  = p.code_level ? -{1'b0, mag} : {1'b0, mag};
            accel_left = accel_ms;
        end

        if (p.take_step) begin
            r.step    = held_step;
            held_step = '0;
        end
        if (p.take_press && pend_ev == EV_PRESS) begin
            r.press_found = 1'b1;
            pend_ev       = EV_NONE;
        end
        if (p.take_long_press && pend_ev == EV_LONG) begin
            r.long_found = 1'b1;
            pend_ev      = EV_NONE;
        end
        if (p.clear_events) begin
            pend_ev   = EV_NONE;
            held_step = '0;
        end
        r.pending = pend_ev;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Bookkeeping
    // ------------------------------------------------------------------
    int n_fail     = 0;
    int n_polls    = 0;
    int n_words    = 0;
    int n_press    = 0;
    int n_long     = 0;
    int n_steps    = 0;
    int n_settings = 0;

    // flow control knobs shared by the test tasks and the receiver
    bit tx_gaps    = 1'b1;
    bit rx_gaps    = 1'b1;
    int hold_req   = 0;
    int hold_left  = 0;
    int stall_left = 0;

    // button level generator for the random part
    bit btn_level  = 1'b0;
    int run_left   = 0;

    function automatic void note_fail(input string msg);
        if (n_fail < 10) $display("ERROR: %s", msg);
        n_fail++;
    endfunction

    // mostly no gap or a short one, now and then a long one
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    task automatic check_word(input result_t got);
        result_t want;
        n_words++;
        if (result_q.size() == 0) begin
            note_fail($sformatf("result word %0d arrived with nothing expected", n_words));
            return;
        end
        want = result_q.pop_front();
        if (want.press_found) n_press++;
        if (want.long_found) n_long++;
        if (want.step != 0) n_steps++;
        if (got.step !== want.step || got.press_found !== want.press_found ||
            got.long_found !== want.long_found || got.pending !== want.pending) begin
            note_fail($sformatf(
                {"word %0d: exp step %0d press %0b long %0b event %0d, ",
                 "got step %0d press %0b long %0b event %0d"},
                n_words, want.step, want.press_found, want.long_found, want.pending,
                got.step, got.press_found, got.long_found, got.pending));
        end
    endtask

    // ------------------------------------------------------------------
    // Result side: check on every handshake, then pick next tready.
    // A requested hold-off is counted down here, ahead of random stalls.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) check_word(result_t'(m_tdata));
        if (hold_req > 0) begin
            hold_left = hold_req;
            hold_req  = 0;
        end
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left--;
        end else begin
            m_tready <= 1'b1;
            if (rx_gaps && $urandom_range(0, 99) < 25) stall_left = gap_len();
        end
    end

    // ------------------------------------------------------------------
    // Poll side
    // ------------------------------------------------------------------
    // Offer one poll word, hold it until accepted, then record its result.
    // tvalid stays high across back-to-back words (one NBA per step).
    task automatic send_poll(input poll_t p);
        int gap;
        gap = tx_gaps ? gap_len() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= p;
        do @(posedge aclk); while (!s_tready);
        result_q.push_back(qualify_poll(p));
        n_polls++;
    endtask

    // Stop offering and wait for every expected word; the block pipes
    // two words deep, and spare clocks after that leave it idle.
    task automatic drain();
        s_tvalid <= 1'b0;
        while (result_q.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // one register write per clock; caller drops cfg_wr_en afterwards
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            CFG_DEBOUNCE:  deb_ms   = val[DEBOUNCE_W-1:0];
            CFG_LONG:      long_ms  = val[LONG_W-1:0];
            CFG_ACCEL:     accel_ms = val[ACCEL_W-1:0];
            CFG_SLOW_STEP: slow_mag = val[STEP_MAG_W-1:0];
            CFG_FAST_STEP: fast_mag = val[STEP_MAG_W-1:0];
            default: ;
        endcase
    endtask

    // New setting only with the block idle. The unused index is hit each
    // time with all ones; it must leave every register as it was.
    task automatic set_regs(input int deb, input int lng, input int acc,
                            input int slw, input int fst);
        drain();
        write_reg(CFG_NONE, '1);
        write_reg(CFG_DEBOUNCE, CFG_DATA_W'(deb));
        write_reg(CFG_LONG, CFG_DATA_W'(lng));
        write_reg(CFG_ACCEL, CFG_DATA_W'(acc));
        write_reg(CFG_SLOW_STEP, CFG_DATA_W'(slw));
        write_reg(CFG_FAST_STEP, CFG_DATA_W'(fst));
        cfg_wr_en <= 1'b0;
        n_settings++;
    endtask

    // Random polls: button held in runs (with short bounce runs), random
    // ticks, edges and requests; one word in ten is pure noise.
    task automatic run_mixed(input int n, input int max_run);
        poll_t p;
        repeat (n) begin
            if (run_left == 0) begin
                btn_level = !btn_level;
                run_left  = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 2)
                                                        : $urandom_range(1, max_run);
            end
            run_left--;
            if ($urandom_range(0, 9) == 0) begin
                p = S_DATA_W'($urandom_range(0, 255));
            end else begin
                p                 = '0;
                p.tick_ms         = 1'($urandom_range(0, 1));
                p.button_pressed  = btn_level;
                p.edge_seen       = ($urandom_range(0, 5) == 0);
                p.code_level      = 1'($urandom_range(0, 1));
                p.take_step       = ($urandom_range(0, 4) == 0);
                p.take_press      = ($urandom_range(0, 4) == 0);
                p.take_long_press = ($urandom_range(0, 4) == 0);
                p.clear_events    = ($urandom_range(0, 29) == 0);
            end
            send_poll(p);
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Reset registers: isolated edge gives 1, an edge inside 20 ms gives 10
    task automatic test_reset_values();
        send_poll(P_EDGE | P_TSTEP);
        send_poll(P_EDGE | P_NEG | P_TSTEP);
        send_poll('0);
        send_poll('1);
    endtask

    // Drives a short press, a long hold, both requests in one word, then a release;
    // debounce loaded by the reset-value test still runs here, so no press is found
    task automatic test_button_press();
        set_regs(1, 3, 2, 5, 127);
        send_poll(P_DOWN | P_TICK);
        send_poll(P_DOWN | P_TICK);
        send_poll(P_TICK);
        send_poll(P_TICK);
        repeat (5) send_poll(P_DOWN | P_TICK);
        send_poll(P_DOWN | P_TPRESS | P_TLONG);
        send_poll(P_TICK);
        send_poll(P_TICK | P_TPRESS);
    endtask

    // Zero debounce and long-press time; tickless polls leave the earlier debounce running
    task automatic test_zero_intervals();
        set_regs(0, 0, 0, 0, 0);
        send_poll(P_DOWN);
        send_poll(P_DOWN);
        send_poll(P_DOWN | P_TLONG | P_TSTEP | P_EDGE);
        send_poll(P_DOWN);
        send_poll(P_CLEAR);
    endtask

    // Zero magnitude, edge overwrite, clear, then every register at its top
    task automatic test_encoder_steps();
        set_regs(100, 3000, 3, 0, 127);
        send_poll(P_EDGE);
        send_poll(P_EDGE | P_NEG | P_TSTEP);
        send_poll(P_EDGE | P_TICK | P_TSTEP);
        send_poll(P_EDGE | P_CLEAR);
        send_poll(P_TSTEP);
        // all-ones writes, masked to each register width
        set_regs('1, '1, '1, '1, '1);
        send_poll(P_EDGE | P_NEG | P_TSTEP);
        send_poll(P_EDGE | P_TICK | P_TSTEP);
    endtask

    // Receiver holds off for a long stretch while polls keep coming;
    // the block fills and s_tready must drop. Then the sender waits out.
    task automatic test_backpressure();
        set_regs(2, 10, 4, 3, 20);
        tx_gaps  = 1'b0;
        hold_req = 120;
        run_mixed(40, 15);
        drain();
        tx_gaps  = 1'b1;
    endtask

    // Main random traffic over several register settings
    task automatic test_random_settings();
        int k;
        set_regs(2, 12, 5, 3, 40);
        run_mixed(400, 30);
        // back-to-back on both sides, zero timers
        set_regs(0, 0, 0, 127, 1);
        tx_gaps = 1'b0;
        rx_gaps = 1'b0;
        run_mixed(400, 10);
        tx_gaps = 1'b1;
        rx_gaps = 1'b1;
        // top settings: only the encoder path moves much here
        set_regs(1023, 65535, 255, 1, 127);
        run_mixed(200, 40);
        for (k = 0; k < 4; k++) begin
            set_regs($urandom_range(0, 6), $urandom_range(0, 40), $urandom_range(0, 12),
                     $urandom_range(1, 127), $urandom_range(1, 127));
            run_mixed(150, 25);
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_values();
        test_button_press();
        test_zero_intervals();
        test_encoder_steps();
        test_backpressure();
        test_random_settings();

        drain();
        repeat (20) @(posedge aclk);

        $display("Covered %0d polls over %0d register settings plus reset values;",
                 n_polls, n_settings);
        $display("read back %0d presses, %0d long presses, %0d nonzero steps; %0d errors.",
                 n_press, n_long, n_steps, n_fail);
        if (n_fail == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // hard stop, far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
